FILE: hw/rtl/slipd_pkg.sv
// Shared types and constants for the SLIP deframer with length check.
package slipd_pkg;

  localparam int unsigned MTU_BYTES   = 1280;
  localparam int unsigned STORE_BYTES = 2562;

  localparam int unsigned CFG_LEN_W = 11;
  localparam int unsigned CNT_W     = 12;
  localparam int unsigned STAT_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_LEN_W-1:0] MIN_LEN_RESET = CFG_LEN_W'(40);
  localparam logic [CFG_LEN_W-1:0] MAX_LEN_RESET = CFG_LEN_W'(MTU_BYTES);
  localparam logic [CNT_W-1:0]     STORE_LIMIT   = CNT_W'(STORE_BYTES);

  localparam logic [7:0] CODE_END     = 8'hC0;
  localparam logic [7:0] CODE_ESC     = 8'hDB;
  localparam logic [7:0] CODE_ESC_END = 8'hDC;
  localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = CFG_IDX_W'(1);

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  localparam logic [2:0] ST_GOOD     = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_LONG     = 3'd2;
  localparam logic [2:0] ST_BAD_ESC  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef struct packed {
    logic              kind;
    logic [7:0]        data_byte;
    logic [CNT_W-1:0]  frame_length;
    logic [2:0]        status;
    logic [STAT_W-1:0] good_frames;
    logic [STAT_W-1:0] bad_frames;
  } result_t;

  typedef struct packed {
    logic [CFG_LEN_W-1:0] min_len;
    logic [CFG_LEN_W-1:0] max_len;
  } limits_t;

endpackage

FILE: hw/rtl/slipd_if.sv
// Stream interfaces for raw input bytes and decoded results.
interface slipd_in_if import slipd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slipd_out_if import slipd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [7:0]        data_byte;
  logic [CNT_W-1:0]  frame_length;
  logic [2:0]        status;
  logic [STAT_W-1:0] good_frames;
  logic [STAT_W-1:0] bad_frames;

  modport source (output valid, output kind, output data_byte, output frame_length,
                  output status, output good_frames, output bad_frames, input ready);
  modport sink   (input valid, input kind, input data_byte, input frame_length,
                  input status, input good_frames, input bad_frames, output ready);
endinterface

FILE: hw/rtl/slipd_cfg_regs.sv
// Configuration registers holding the frame length limits.
module slipd_cfg_regs import slipd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_LEN_W-1:0] wr_data,
  output limits_t              limits
);

  logic [CFG_LEN_W-1:0] min_len_r;
  logic [CFG_LEN_W-1:0] max_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RESET;
      max_len_r <= MAX_LEN_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_MIN_LEN: min_len_r <= wr_data;
        CFG_MAX_LEN: max_len_r <= wr_data;
        default: ;
      endcase
    end
  end

  assign limits.min_len = min_len_r;
  assign limits.max_len = max_len_r;

endmodule

FILE: hw/rtl/slipd_decode.sv
// Unstuffing, frame length check and frame counters for one byte per transfer.
module slipd_decode import slipd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  limits_t    limits,
  output logic       res_valid,
  output result_t    res
);

  logic              escape_pending_r, escape_pending_nxt;
  logic              frame_open_r, frame_open_nxt;
  logic              discarding_r, discarding_nxt;
  logic [CNT_W-1:0]  byte_count_r, byte_count_nxt;
  logic [STAT_W-1:0] good_count_r, good_count_nxt;
  logic [STAT_W-1:0] error_count_r, error_count_nxt;

  logic       have_data;
  logic [7:0] data_val;
  logic       bad_esc;
  logic       raise_err;
  logic [2:0] err_status;
  logic [CNT_W-1:0] min_ext;
  logic [CNT_W-1:0] max_ext;

  assign min_ext = {1'b0, limits.min_len};
  assign max_ext = {1'b0, limits.max_len};

  always_comb begin
    escape_pending_nxt = escape_pending_r;
    frame_open_nxt     = frame_open_r;
    discarding_nxt     = discarding_r;
    byte_count_nxt     = byte_count_r;
    good_count_nxt     = good_count_r;
    error_count_nxt    = error_count_r;
    have_data          = 1'b0;
    data_val           = rx_byte;
    bad_esc            = 1'b0;
    raise_err          = 1'b0;
    err_status         = ST_BAD_ESC;
    res_valid          = 1'b0;
    res.kind           = KIND_MARKER;
    res.data_byte      = 8'd0;
    res.frame_length   = byte_count_r;
    res.status         = ST_GOOD;

    if (rx_byte == CODE_END) begin
      if (frame_open_r && !discarding_r && byte_count_r != '0) begin
        res_valid = 1'b1;
        if (byte_count_r < min_ext) begin
          res.status      = ST_SHORT;
          error_count_nxt = error_count_r + STAT_W'(1);
        end else if (byte_count_r > max_ext) begin
          res.status      = ST_LONG;
          error_count_nxt = error_count_r + STAT_W'(1);
        end else begin
          res.status     = ST_GOOD;
          good_count_nxt = good_count_r + STAT_W'(1);
        end
      end
      byte_count_nxt     = '0;
      escape_pending_nxt = 1'b0;
      discarding_nxt     = 1'b0;
      frame_open_nxt     = 1'b1;
    end else if (!discarding_r) begin
      frame_open_nxt = 1'b1;
      if (escape_pending_r) begin
        escape_pending_nxt = 1'b0;
        if (rx_byte == CODE_ESC_END) begin
          data_val  = CODE_END;
          have_data = 1'b1;
        end else if (rx_byte == CODE_ESC_ESC) begin
          data_val  = CODE_ESC;
          have_data = 1'b1;
        end else begin
          bad_esc = 1'b1;
        end
      end else if (rx_byte == CODE_ESC) begin
        escape_pending_nxt = 1'b1;
      end else begin
        have_data = 1'b1;
      end

      if (bad_esc) begin
        raise_err  = 1'b1;
        err_status = ST_BAD_ESC;
      end else if (have_data) begin
        if (byte_count_r < STORE_LIMIT) begin
          byte_count_nxt   = byte_count_r + CNT_W'(1);
          res_valid        = 1'b1;
          res.kind         = KIND_DATA;
          res.data_byte    = data_val;
          res.frame_length = byte_count_nxt;
        end else begin
          raise_err  = 1'b1;
          err_status = ST_OVERFLOW;
        end
      end

      if (raise_err) begin
        res_valid          = 1'b1;
        res.status         = err_status;
        error_count_nxt    = error_count_r + STAT_W'(1);
        byte_count_nxt     = '0;
        frame_open_nxt     = 1'b0;
        discarding_nxt     = 1'b1;
        escape_pending_nxt = 1'b0;
      end
    end

    res.good_frames = good_count_nxt;
    res.bad_frames  = error_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_pending_r <= 1'b0;
      frame_open_r     <= 1'b0;
      discarding_r     <= 1'b0;
      byte_count_r     <= '0;
      good_count_r     <= '0;
      error_count_r    <= '0;
    end else if (step) begin
      escape_pending_r <= escape_pending_nxt;
      frame_open_r     <= frame_open_nxt;
      discarding_r     <= discarding_nxt;
      byte_count_r     <= byte_count_nxt;
      good_count_r     <= good_count_nxt;
      error_count_r    <= error_count_nxt;
    end
  end

  a_discard_empty: assert property (@(posedge clk) disable iff (!rst_n)
    discarding_r |-> (byte_count_r == '0 && !escape_pending_r && !frame_open_r))
    else $error("discarding with frame state left over");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= STORE_LIMIT)
    else $error("byte count beyond store size");

  a_counters_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(step) |-> ($stable(good_count_r) && $stable(error_count_r)))
    else $error("frame counters moved without a transfer");

  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_valid && res.kind == KIND_DATA) |=> (byte_count_r != '0))
    else $error("data byte left an empty frame");

endmodule

FILE: hw/rtl/slipd_out_reg.sv
// Result register between the decoder and the output channel.
module slipd_out_reg import slipd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_res,
  output logic    space,
  slipd_out_if.source out_ch
);

  logic    valid_r;
  result_t res_r;

  assign space = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.kind         = res_r.kind;
  assign out_ch.data_byte    = res_r.data_byte;
  assign out_ch.frame_length = res_r.frame_length;
  assign out_ch.status       = res_r.status;
  assign out_ch.good_frames  = res_r.good_frames;
  assign out_ch.bad_frames   = res_r.bad_frames;

endmodule

FILE: hw/rtl/slip_deframer_with_length_check_core.sv
// Top level of the SLIP deframer with frame length check.
//
// in_ch carries one raw byte from the serial link per transfer; out_ch carries
// at most one result per byte: a decoded data byte (kind 0) or a frame-end or
// error marker (kind 1) with length, status and the running good and bad
// frame counts. END bytes that close no frame, lone ESC bytes, and bytes
// dropped after an error give no result.
// A byte sits in the input register while it is decoded, and its result is
// loaded into the result register when the decode step fires; out_ch.valid
// then rises, and the result is taken when out_ch is ready. One byte is
// taken every cycle while out_ch is ready; the decode step between the input
// and result registers sets this.
// When out_ch stalls, the result register holds its result, the input
// register fills, and in_ch.ready falls until the result is taken.
// cfg_wr_en with cfg_index writes min_frame_len (0) or max_frame_len (1);
// write them only while no byte is in flight.
// Reset (rst_n low, synchronous) clears the pipeline, the frame state and
// both counters, and sets the limits to 40 and 1280.
module slip_deframer_with_length_check_core import slipd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_LEN_W-1:0] cfg_wr_data,
  slipd_in_if.sink             in_ch,
  slipd_out_if.source          out_ch
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       step;
  logic       space;
  logic       res_valid;
  result_t    res;
  limits_t    limits;

  assign step        = in_valid_r && space;
  assign in_ch.ready = !in_valid_r || space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  slipd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_wr_data),
    .limits   (limits)
  );

  slipd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (in_byte_r),
    .limits    (limits),
    .res_valid (res_valid),
    .res       (res)
  );

  slipd_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step && res_valid),
    .load_res (res),
    .space    (space),
    .out_ch   (out_ch)
  );

endmodule

FILE: bench/slip_deframer_with_length_check_core_test.sv
// Testbench for the SLIP deframer: directed and random byte streams checked by a decoder.
module slip_deframer_with_length_check_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import slipd_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 1_000_000;

  typedef enum logic [1:0] {CHECK_PREDICTED, CHECK_SILENT, CHECK_TYPED} row_mode_t;

  typedef struct {
    logic [7:0] rx;
    row_mode_t  mode;
    result_t    typed;
  } link_byte_t;

  typedef struct {
    logic [CFG_LEN_W-1:0] lo;
    logic [CFG_LEN_W-1:0] hi;
    int                   budget;
    int                   span;
    bit                   idle;
    bit                   hold;
    bit                   oversize;
  } phase_t;

  logic clk;
  logic rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_LEN_W-1:0] cfg_wr_data;

  slipd_in_if  in_ch();
  slipd_out_if out_ch();

  slip_deframer_with_length_check_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Decoder state
  logic [CFG_LEN_W-1:0] min_len     = MIN_LEN_RESET;
  logic [CFG_LEN_W-1:0] max_len     = MAX_LEN_RESET;
  bit                   esc_pend    = 1'b0;
  bit                   frame_open  = 1'b0;
  bit                   dropping    = 1'b0;
  logic [CNT_W-1:0]     frame_count = '0;
  logic [STAT_W-1:0]    good_total  = '0;
  logic [STAT_W-1:0]    bad_total   = '0;

  result_t     awaited_results[$];
  link_byte_t  link_bytes[$];
  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          idle_on        = 1'b1;
  bit          hold_go        = 1'b0;
  logic        hold_active    = 1'b0;

  link_byte_t directed_rows [19] = '{
    '{8'h00,        CHECK_TYPED,  '{KIND_DATA,   8'h00, 12'd1, ST_GOOD,    32'd0, 32'd0}},
    '{8'hFF,        CHECK_TYPED,  '{KIND_DATA,   8'hFF, 12'd2, ST_GOOD,    32'd0, 32'd0}},
    '{CODE_END,     CHECK_TYPED,  '{KIND_MARKER, 8'h00, 12'd2, ST_SHORT,   32'd0, 32'd1}},
    '{CODE_END,     CHECK_SILENT, '0},
    '{CODE_ESC,     CHECK_SILENT, '0},
    '{CODE_ESC_END, CHECK_TYPED,  '{KIND_DATA,   8'hC0, 12'd1, ST_GOOD,    32'd0, 32'd1}},
    '{CODE_ESC,     CHECK_SILENT, '0},
    '{CODE_ESC_ESC, CHECK_TYPED,  '{KIND_DATA,   8'hDB, 12'd2, ST_GOOD,    32'd0, 32'd1}},
    '{CODE_ESC,     CHECK_SILENT, '0},
    '{8'h41,        CHECK_TYPED,  '{KIND_MARKER, 8'h00, 12'd2, ST_BAD_ESC, 32'd0, 32'd2}},
    '{8'h55,        CHECK_SILENT, '0},
    '{CODE_ESC,     CHECK_SILENT, '0},
    '{CODE_END,     CHECK_SILENT, '0},
    '{8'hAA,        CHECK_TYPED,  '{KIND_DATA,   8'hAA, 12'd1, ST_GOOD,    32'd0, 32'd2}},
    '{CODE_ESC,     CHECK_SILENT, '0},
    '{CODE_END,     CHECK_TYPED,  '{KIND_MARKER, 8'h00, 12'd1, ST_SHORT,   32'd0, 32'd3}},
    '{CODE_ESC_END, CHECK_TYPED,  '{KIND_DATA,   8'hDC, 12'd1, ST_GOOD,    32'd0, 32'd3}},
    '{CODE_ESC_ESC, CHECK_TYPED,  '{KIND_DATA,   8'hDD, 12'd2, ST_GOOD,    32'd0, 32'd3}},
    '{CODE_END,     CHECK_TYPED,  '{KIND_MARKER, 8'h00, 12'd2, ST_SHORT,   32'd0, 32'd4}}
  };

  phase_t phases [7] = '{
    '{11'd1,    11'd8,    240, 12, 1'b1, 1'b0, 1'b0},
    '{11'd0,    11'd0,    200, 4,  1'b0, 1'b0, 1'b0},
    '{11'd5,    11'd3,    240, 8,  1'b1, 1'b0, 1'b0},
    '{11'd0,    11'd1280, 240, 30, 1'b0, 1'b1, 1'b0},
    '{11'd1280, 11'd1280, 200, 6,  1'b1, 1'b0, 1'b0},
    '{11'd12,   11'd1023, 240, 30, 1'b1, 1'b0, 1'b1},
    '{11'd40,   11'd1280, 240, 60, 1'b1, 1'b0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic result_t marker(input logic [2:0] st);
    result_t r;
    r = '0;
    r.kind         = KIND_MARKER;
    r.frame_length = frame_count;
    r.status       = st;
    r.good_frames  = good_total;
    r.bad_frames   = bad_total;
    return r;
  endfunction

  function automatic result_t drop_frame(input logic [2:0] st);
    result_t r;
    bad_total++;
    r = marker(st);
    frame_count = '0;
    frame_open  = 1'b0;
    dropping    = 1'b1;
    esc_pend    = 1'b0;
    return r;
  endfunction

  function automatic bit decode_link_byte(input logic [7:0] rx, output result_t res);
    logic [7:0] b;
    logic [2:0] st;
    bit         hit;
    b   = rx;
    hit = 1'b0;
    res = '0;
    if (rx == CODE_END) begin
      if (frame_open && !dropping && frame_count != '0) begin
        if (frame_count < min_len) begin
          st = ST_SHORT;
          bad_total++;
        end else if (frame_count > max_len) begin
          st = ST_LONG;
          bad_total++;
        end else begin
          st = ST_GOOD;
          good_total++;
        end
        res = marker(st);
        hit = 1'b1;
      end
      frame_count = '0;
      esc_pend    = 1'b0;
      dropping    = 1'b0;
      frame_open  = 1'b1;
      return hit;
    end
    if (dropping) return 1'b0;
    frame_open = 1'b1;
    if (esc_pend) begin
      esc_pend = 1'b0;
      if (rx == CODE_ESC_END) begin
        b = CODE_END;
      end else if (rx == CODE_ESC_ESC) begin
        b = CODE_ESC;
      end else begin
        res = drop_frame(ST_BAD_ESC);
        return 1'b1;
      end
    end else if (rx == CODE_ESC) begin
      esc_pend = 1'b1;
      return 1'b0;
    end
    if (frame_count >= STORE_LIMIT) begin
      res = drop_frame(ST_OVERFLOW);
      return 1'b1;
    end
    frame_count++;
    res.kind         = KIND_DATA;
    res.data_byte    = b;
    res.frame_length = frame_count;
    res.status       = ST_GOOD;
    res.good_frames  = good_total;
    res.bad_frames   = bad_total;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] random_payload();
    if ($urandom_range(0, 9) < 2) begin
      case ($urandom_range(0, 3))
        0: return CODE_END;
        1: return CODE_ESC;
        2: return CODE_ESC_END;
        default: return CODE_ESC_ESC;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic string field_line(input string name, input logic [31:0] got,
                                       input logic [31:0] want);
    return $sformatf("%s mismatch: got %0d, want %0d", name, got, want);
  endfunction

  task automatic report(input string line);
    mismatch_count++;
    if (mismatch_count <= 100) $display("[%0t] %s", $time, line);
  endtask

  task automatic queue_raw(input logic [7:0] b);
    link_bytes.push_back('{b, CHECK_PREDICTED, '0});
  endtask

  // Stuff END and ESC, close with END
  task automatic queue_frame(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = random_payload();
      if (b == CODE_END) begin
        queue_raw(CODE_ESC);
        queue_raw(CODE_ESC_END);
      end else if (b == CODE_ESC) begin
        queue_raw(CODE_ESC);
        queue_raw(CODE_ESC_ESC);
      end else begin
        queue_raw(b);
      end
    end
    queue_raw(CODE_END);
  endtask

  task automatic queue_noise();
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0: begin
        repeat ($urandom_range(1, 6)) queue_raw(random_payload());
      end
      1: begin
        do b = 8'($urandom_range(0, 255));
        while (b == CODE_ESC_END || b == CODE_ESC_ESC);
        queue_raw(CODE_ESC);
        queue_raw(b);
      end
      default: begin
        queue_raw(CODE_ESC);
        queue_raw(CODE_END);
      end
    endcase
  endtask

  task automatic build_stream(input int budget, input int span);
    int n;
    while (link_bytes.size() < budget) begin
      if ($urandom_range(0, 99) < 85) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2 * span) : $urandom_range(0, span);
        queue_frame(n);
      end else begin
        queue_noise();
      end
    end
  endtask

  task automatic send_byte(input link_byte_t item);
    int      gap;
    bit      hit;
    result_t res;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= item.rx;
    do @(posedge clk);
    while (!in_ch.ready);
    hit = decode_link_byte(item.rx, res);
    case (item.mode)
      CHECK_PREDICTED: if (hit) awaited_results.push_back(res);
      CHECK_TYPED: awaited_results.push_back(item.typed);
      default: ;
    endcase
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limits(input logic [CFG_LEN_W-1:0] lo, input logic [CFG_LEN_W-1:0] hi);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= CFG_MIN_LEN;
    cfg_wr_data <= lo;
    @(posedge clk);
    cfg_index   <= CFG_MAX_LEN;
    cfg_wr_data <= hi;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    min_len = lo;
    max_len = hi;
  endtask

  task automatic check_result();
    result_t want;
    if (awaited_results.size() == 0) begin
      report($sformatf("result with nothing awaited: kind %0d length %0d status %0d",
                       out_ch.kind, out_ch.frame_length, out_ch.status));
      return;
    end
    want = awaited_results.pop_front();
    if (out_ch.kind !== want.kind)
      report(field_line("kind", 32'(out_ch.kind), 32'(want.kind)));
    if (out_ch.data_byte !== want.data_byte)
      report(field_line("data_byte", 32'(out_ch.data_byte), 32'(want.data_byte)));
    if (out_ch.frame_length !== want.frame_length)
      report(field_line("frame_length", 32'(out_ch.frame_length), 32'(want.frame_length)));
    if (out_ch.status !== want.status)
      report(field_line("status", 32'(out_ch.status), 32'(want.status)));
    if (out_ch.good_frames !== want.good_frames)
      report(field_line("good_frames", out_ch.good_frames, want.good_frames));
    if (out_ch.bad_frames !== want.bad_frames)
      report(field_line("bad_frames", out_ch.bad_frames, want.bad_frames));
  endtask

  initial begin : result_sink
    int   stall;
    logic next_ready;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_result();
      if (hold_active) begin
        next_ready = 1'b0;
      end else if (stall != 0) begin
        stall--;
        next_ready = (stall == 0);
      end else begin
        stall = pick_gap();
        next_ready = (stall == 0);
      end
      out_ch.ready <= next_ready;
    end
  end

  // Hold the result side off so the pipeline fills and stalls the input
  initial begin : long_hold
    wait (hold_go);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_index     = CFG_MIN_LEN;
    cfg_wr_data   = '0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(directed_rows); i++) send_byte(directed_rows[i]);
    drain();

    for (int p = 0; p < $size(phases); p++) begin
      write_limits(phases[p].lo, phases[p].hi);
      idle_on = phases[p].idle;
      if (phases[p].hold) hold_go = 1'b1;
      if (phases[p].oversize) queue_frame(STORE_BYTES + 3);
      build_stream(phases[p].budget, phases[p].span);
      while (link_bytes.size() != 0) send_byte(link_bytes.pop_front());
      drain();
    end

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/slipd_pkg.sv
hw/rtl/slipd_if.sv
hw/rtl/slipd_cfg_regs.sv
hw/rtl/slipd_decode.sv
hw/rtl/slipd_out_reg.sv
hw/rtl/slip_deframer_with_length_check_core.sv
bench/slip_deframer_with_length_check_core_test.sv
